// File: hdl/ftec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftec_pkg: shared types and constants of the file-name escape codec
// Character codes, the escape letter tables and the command that travels
// from the classifying front end to the output sequencer.
// ----------------------------------------------------------------------------
package ftec_pkg;

  // Character codes used by the escape scheme.
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChTilde     = 8'h7E;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChQuery     = 8'h3F;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChLess      = 8'h3C;
  localparam logic [7:0] ChGreater   = 8'h3E;
  localparam logic [7:0] ChBar       = 8'h7C;
  localparam logic [7:0] ChLowS      = 8'h73;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowC      = 8'h63;
  localparam logic [7:0] ChLowQ      = 8'h71;
  localparam logic [7:0] ChLowD      = 8'h64;
  localparam logic [7:0] ChLowL      = 8'h6C;
  localparam logic [7:0] ChLowG      = 8'h67;
  localparam logic [7:0] ChLowV      = 8'h76;

  // Direction register codes.
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // One queued command: one or two output bytes for a single input beat.
  typedef struct packed {
    logic       two_bytes;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
  } ftec_cmd_t;

  // Escape letter for a character in the encode direction; NUL if none.
  function automatic logic [7:0] escape_letter(input logic [7:0] c);
    logic [7:0] k;
    begin
      case (c)
        ChStar:      k = ChLowS;
        ChBackslash: k = ChLowB;
        ChColon:     k = ChLowC;
        ChQuery:     k = ChLowQ;
        ChQuote:     k = ChLowD;
        ChLess:      k = ChLowL;
        ChGreater:   k = ChLowG;
        ChBar:       k = ChLowV;
        ChTilde:     k = ChTilde;
        default:     k = ChNul;
      endcase
      return k;
    end
  endfunction

  // Character named by an escape letter in the decode direction; NUL if unknown.
  function automatic logic [7:0] unescape_letter(input logic [7:0] c);
    logic [7:0] m;
    begin
      case (c)
        ChLowS:  m = ChStar;
        ChLowB:  m = ChBackslash;
        ChLowC:  m = ChColon;
        ChLowQ:  m = ChQuery;
        ChLowD:  m = ChQuote;
        ChLowL:  m = ChLess;
        ChLowG:  m = ChGreater;
        ChLowV:  m = ChBar;
        ChTilde: m = ChTilde;
        default: m = ChNul;
      endcase
      return m;
    end
  endfunction

endpackage

// File: hdl/ftec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftec_front: input classifier
// Accepts input beats, maps each byte to a command of one or two output
// bytes and keeps the pending-tilde flag of the decode direction.
// ----------------------------------------------------------------------------
module ftec_front
  import ftec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       direction,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output ftec_cmd_t  cmd
);

  logic       escape_pending;
  logic       escape_pending_next;
  logic       emits;
  logic       accept;
  logic [7:0] esc_k;
  logic [7:0] unesc_m;

  assign esc_k   = escape_letter(in_byte);
  assign unesc_m = unescape_letter(in_byte);

  // Input is taken whenever the queue has room, even for a byte that emits nothing.
  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = in_valid && emits;

  // Classify the byte into the output it causes.
  always_comb begin
    emits               = 1'b1;
    cmd.two_bytes       = 1'b0;
    cmd.byte_a          = in_byte;
    cmd.byte_b          = in_byte;
    escape_pending_next = escape_pending;
    if (direction == DirEncode) begin
      if (in_byte == ChSlash) begin
        cmd.byte_a = ChBackslash;
      end else if (esc_k != ChNul) begin
        cmd.two_bytes = 1'b1;
        cmd.byte_a    = ChTilde;
        cmd.byte_b    = esc_k;
      end
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (unesc_m != ChNul) begin
        cmd.byte_a = unesc_m;
      end else begin
        cmd.two_bytes = 1'b1;
        cmd.byte_a    = ChTilde;
        cmd.byte_b    = in_byte;
      end
    end else if (in_byte == ChTilde) begin
      emits               = 1'b0;
      escape_pending_next = 1'b1;
    end else if (in_byte == ChBackslash) begin
      cmd.byte_a = ChSlash;
    end
  end

  // Pending-tilde flag advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

// File: hdl/ftec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftec_queue: command queue
// Small register FIFO that decouples the classifier from the output side.
// ----------------------------------------------------------------------------
module ftec_queue
  import ftec_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  ftec_cmd_t push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output ftec_cmd_t pop_cmd
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ftec_cmd_t         slots [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ftec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftec_back: output sequencer
// Pops commands and presents their one or two bytes from an output register,
// marking the final byte of each command.
// ----------------------------------------------------------------------------
module ftec_back
  import ftec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  ftec_cmd_t  cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  logic       load;
  logic       second_pending;
  logic [7:0] held_byte;

  // The output register may be reloaded when empty or when its beat is taken.
  assign load      = !out_valid || out_ready;
  assign cmd_ready = load && !second_pending;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (load) begin
      if (second_pending) begin
        out_valid      <= 1'b1;
        second_pending <= 1'b0;
      end else begin
        out_valid      <= cmd_valid;
        second_pending <= cmd_valid && cmd.two_bytes;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      if (second_pending) begin
        out_byte    <= held_byte;
        last_of_run <= 1'b1;
      end else if (cmd_valid) begin
        out_byte    <= cmd.byte_a;
        last_of_run <= !cmd.two_bytes;
        held_byte   <= cmd.byte_b;
      end
    end
  end

endmodule

// File: hdl/filename_tilde_escape_codec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filename_tilde_escape_codec_core: file-name tilde escape codec
// Converts file-name bytes to and from the tilde-escaped form, one input
// beat at a time, in the direction chosen by a register.
//
//   Channel   Signals                          Beat carries
//   input     in_valid / in_ready              in_byte
//   output    out_valid / out_ready            out_byte, last_of_run
//   config    direction_we                     direction_wdata
//
// One input beat is accepted per cycle while the queue has room; a byte that
// expands to two outputs holds the output register for both, which sets the rate.
// A tilde in the decode direction produces no output beat unless a tilde is pending.
// Input reaches the output through the queue and then the output register.
// Reset clears the direction, the pending tilde, the queue and the output.
// The command queue lets input continue while the output side is stalled.
// ----------------------------------------------------------------------------
module filename_tilde_escape_codec_core
  import ftec_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       direction_we,
  input  logic       direction_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  logic      direction;
  logic      front_valid;
  logic      front_ready;
  ftec_cmd_t front_cmd;
  logic      back_valid;
  logic      back_ready;
  ftec_cmd_t back_cmd;

  // Direction register.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DirEncode;
    end else if (direction_we) begin
      direction <= direction_wdata;
    end
  end

  // Classifier.
  ftec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Command queue.
  ftec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // Output sequencer.
  ftec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (back_valid),
    .cmd_ready   (back_ready),
    .cmd         (back_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

// File: sim/filename_tilde_escape_codec_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filename_tilde_escape_codec_core_tb: self-checking bench for the escape codec
// Sends file-name bytes through the codec in both directions, with random
// gaps on the input and output channels. Each output beat is predicted from
// the accepted input stream and compared, in order, with what the codec gives.
// ----------------------------------------------------------------------------
module filename_tilde_escape_codec_core_tb;
  import ftec_pkg::*;

  // Cycles allowed for the codec to settle after the last expected beat.
  localparam int         SettleCycles = 4;
  localparam logic [7:0] ChLowF       = 8'h66;
  localparam logic [7:0] ChUpperA     = 8'h41;
  localparam logic [7:0] ChAllOnes    = 8'hFF;
  localparam logic [7:0] ChTopBit     = 8'h80;

  // One predicted output beat.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  logic       clk;
  logic       rst;
  logic       direction_we;
  logic       direction_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  out_char_t  pending_chars[$];
  logic       model_dir;
  logic       tilde_held;
  int         error_count;
  bit         steady;
  int         hold_request;

  filename_tilde_escape_codec_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .direction_we    (direction_we),
    .direction_wdata (direction_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last_of_run     (last_of_run)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Escape table entry: {plain character, escape letter}.
  function automatic logic [15:0] escape_entry(input int idx);
    case (idx)
      0:       return {ChStar,      ChLowS};
      1:       return {ChBackslash, ChLowB};
      2:       return {ChColon,     ChLowC};
      3:       return {ChQuery,     ChLowQ};
      4:       return {ChQuote,     ChLowD};
      5:       return {ChLess,      ChLowL};
      6:       return {ChGreater,   ChLowG};
      7:       return {ChBar,       ChLowV};
      default: return {ChTilde,     ChTilde};
    endcase
  endfunction

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // Random name character, biased towards the characters that need escaping.
  function automatic logic [7:0] random_char();
    logic [15:0] entry;
    logic [7:0]  r;
    entry = escape_entry($urandom_range(0, 8));
    r     = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1, 2: return entry[15:8];
      3:       return $urandom_range(0, 1) ? ChSlash : ChBackslash;
      4:       return ChNul;
      default: return r;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < 50)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic expect_char(input logic [7:0] ch, input logic last);
    out_char_t e;
    e.ch   = ch;
    e.last = last;
    pending_chars.push_back(e);
  endtask

  // Works out the output beats caused by one accepted input byte.
  task automatic predict_chars(input logic [7:0] c);
    logic [15:0] entry;
    logic        hit;
    hit = 1'b0;
    if (model_dir == DirEncode) begin
      for (int i = 0; i < 9; i++) begin
        if (!hit && escape_entry(i) >> 8 == c) begin
          entry = escape_entry(i);
          hit   = 1'b1;
        end
      end
      if (c == ChSlash) begin
        expect_char(ChBackslash, 1'b1);
      end else if (hit) begin
        expect_char(ChTilde, 1'b0);
        expect_char(entry[7:0], 1'b1);
      end else begin
        expect_char(c, 1'b1);
      end
    end else if (tilde_held) begin
      tilde_held = 1'b0;
      for (int i = 0; i < 9; i++) begin
        if (!hit && escape_entry(i) % 256 == c) begin
          entry = escape_entry(i);
          hit   = 1'b1;
        end
      end
      if (hit) begin
        expect_char(entry[15:8], 1'b1);
      end else begin
        // An unknown letter, or the terminator, keeps its tilde.
        expect_char(ChTilde, 1'b0);
        expect_char(c, 1'b1);
      end
    end else if (c == ChTilde) begin
      tilde_held = 1'b1;
    end else if (c == ChBackslash) begin
      expect_char(ChSlash, 1'b1);
    end else begin
      expect_char(c, 1'b1);
    end
  endtask

  // Offers one byte after a random gap and waits for the handshake.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_chars(c);
  endtask

  // Stops sending and waits until every expected beat has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_direction(input logic d);
    wait_drained();
    direction_we    <= 1'b1;
    direction_wdata <= d;
    @(posedge clk);
    model_dir = d;
    direction_we <= 1'b0;
  endtask

  // Encode: extremes, the slash, every escaped character and plain bytes.
  task automatic test_encode_directed();
    logic [15:0] entry;
    write_direction(DirEncode);
    send_char(ChNul);
    send_char(ChAllOnes);
    send_char(ChSlash);
    for (int i = 0; i < 9; i++) begin
      entry = escape_entry(i);
      send_char(entry[15:8]);
    end
    send_char(ChUpperA);
    send_char(ChTopBit);
  endtask

  // Decode: backslash, known and unknown letters, terminator after a tilde.
  task automatic test_decode_directed();
    write_direction(DirDecode);
    send_char(ChBackslash);
    send_char(ChTilde);
    send_char(ChLowS);
    send_char(ChTilde);
    send_char(ChTilde);
    send_char(ChTilde);
    send_char(ChLowF);
    send_char(ChTilde);
    send_char(ChBackslash);
    send_char(ChTilde);
    send_char(ChNul);
    send_char(ChNul);
    send_char(ChAllOnes);
  endtask

  // A pending tilde survives a trip through the encode direction.
  task automatic test_direction_switch();
    send_char(ChTilde);
    write_direction(DirEncode);
    send_char(ChStar);
    write_direction(DirDecode);
    send_char(ChLowC);
  endtask

  // The receiver holds off for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    steady       = 1'b1;
    hold_request = 60;
    for (int i = 0; i < 24; i++) send_char(random_char());
    steady = 1'b0;
    wait_drained();
  endtask

  // Random names in phases (encode, then decode, then random directions), mostly
  // escape pairs when decoding, with one phase at full rate.
  task automatic test_random_names();
    logic [15:0] entry;
    logic [7:0]  r;
    int          sent;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 2) write_direction(phase[0] ? DirDecode : DirEncode);
      else write_direction($urandom_range(0, 1) ? DirDecode : DirEncode);
      steady = (phase == 3);
      sent   = 0;
      while (sent < 50) begin
        if (model_dir == DirDecode && $urandom_range(0, 9) < 6) begin
          entry = escape_entry($urandom_range(0, 8));
          r     = 8'($urandom_range(0, 255));
          send_char(ChTilde);
          send_char($urandom_range(0, 4) != 0 ? entry[7:0] : r);
          sent += 2;
        end else begin
          send_char(random_char());
          sent++;
        end
      end
    end
    steady = 1'b0;
  endtask

  // Waits for the last beats, then gives the verdict.
  task automatic finish_run();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_chars.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (pending_chars.size() != 0)
      report_mismatch("expected beats never arrived", pending_chars.size(), 0);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  endtask

  // Output side: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int ready_gap;
    int hold_left;
    ready_gap = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (ready_gap > 0) begin
        out_ready <= 1'b0;
        ready_gap--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) ready_gap = pick_gap();
      end
    end
  end

  // Every accepted output beat is checked against the oldest prediction.
  always @(posedge clk) begin : result_check
    out_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("output beat with nothing expected", out_byte, 0);
      end else begin
        want = pending_chars.pop_front();
        if (out_byte !== want.ch)
          report_mismatch("out_byte", out_byte, want.ch);
        if (last_of_run !== want.last)
          report_mismatch("last_of_run", last_of_run, want.last);
      end
    end
  end

  // Test sequence.
  initial begin
    rst             = 1'b1;
    direction_we    = 1'b0;
    direction_wdata = 1'b0;
    in_valid        = 1'b0;
    in_byte         = 8'h00;
    model_dir       = DirEncode;
    tilde_held      = 1'b0;
    error_count     = 0;
    steady          = 1'b0;
    hold_request    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_directed();
    test_decode_directed();
    test_direction_switch();
    test_backpressure();
    test_random_names();
    finish_run();
  end

endmodule

// File: filename_tilde_escape_codec_core.f
hdl/ftec_pkg.sv
hdl/ftec_front.sv
hdl/ftec_queue.sv
hdl/ftec_back.sv
hdl/filename_tilde_escape_codec_core.sv
sim/filename_tilde_escape_codec_core_tb.sv
